>>> src/esd_pkg.sv
`default_nettype none

package esd_pkg;

  // Table depth default
  localparam int FLOORS_DEFAULT = 16;

  // Field widths
  localparam int FLOOR_W = 4;
  localparam int PASS_W  = 4;
  localparam int WAIT_W  = 8;
  localparam int SCORE_W = 11;
  localparam int LOAD_W  = 8;
  localparam int CNT_W   = 32;
  localparam int THR_W   = 12;
  localparam int NUM_W   = 13;  // est * scale, at most 15 * 307
  localparam int ENTRY_W = PASS_W + WAIT_W;

  // Configuration port
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 12;
  localparam logic [CFG_IW-1:0] CFG_STOP_THRESHOLD = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_CAR_CAPACITY   = 2'd1;
  localparam logic [THR_W-1:0]  THRESHOLD_RESET    = 12'd128;
  localparam logic [LOAD_W-1:0] CAPACITY_RESET     = 8'd8;

  // Scoring constants (scales in Q5.8)
  localparam logic [WAIT_W-1:0] BONUS_WAIT  = 8'd5;
  localparam logic [NUM_W-1:0]  SCALE_PLAIN = 13'd256;
  localparam logic [NUM_W-1:0]  SCALE_BONUS = 13'd307;
  localparam int                STOP_COST   = 2;

  typedef enum logic [1:0] {
    MODE_REG    = 2'd0,
    MODE_AGE    = 2'd1,
    MODE_DECIDE = 2'd2,
    MODE_SERVE  = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REG,
    ST_SCAN,
    ST_SERVE,
    ST_DRAIN,
    ST_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]         mode;
    logic [FLOOR_W-1:0] floor;
    logic [PASS_W-1:0]  passengers;
    logic [FLOOR_W-1:0] car_floor;
    logic               going_up;
  } in_t;

  typedef struct packed {
    logic               target_valid;
    logic [FLOOR_W-1:0] target_floor;
    logic [SCORE_W-1:0] best_score;
    logic [LOAD_W-1:0]  boarded;
    logic [LOAD_W-1:0]  load;
    logic [CNT_W-1:0]   decide_count;
    logic [CNT_W-1:0]   stop_count;
    logic [CNT_W-1:0]   skip_count;
    logic [CNT_W-1:0]   boarded_total;
  } out_t;

  typedef struct packed {
    logic latch;
    logic reg_write;
    logic scan_issue;
    logic serve_issue;
    logic finish;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic pipe_empty;
  } status_t;

endpackage

`default_nettype wire

>>> src/esd_ctrl.sv
`default_nettype none

module esd_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  input  wire logic [1:0]       in_mode,
  input  wire logic             out_ready,
  input  wire esd_pkg::status_t status,
  output logic                  in_ready,
  output logic                  out_valid,
  output esd_pkg::cmd_t         cmd
);

  esd_pkg::state_t state;
  esd_pkg::state_t state_next;
  logic            out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= esd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      esd_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_mode)
            esd_pkg::MODE_REG:                      state_next = esd_pkg::ST_REG;
            esd_pkg::MODE_AGE, esd_pkg::MODE_DECIDE: state_next = esd_pkg::ST_SCAN;
            esd_pkg::MODE_SERVE:                    state_next = esd_pkg::ST_SERVE;
            default:                                state_next = esd_pkg::ST_REG;
          endcase
        end
      end
      esd_pkg::ST_REG:   state_next = esd_pkg::ST_DONE;
      esd_pkg::ST_SCAN: begin
        if (status.scan_last) begin
          state_next = esd_pkg::ST_DRAIN;
        end
      end
      esd_pkg::ST_SERVE: state_next = esd_pkg::ST_DRAIN;
      esd_pkg::ST_DRAIN: begin
        if (status.pipe_empty) begin
          state_next = esd_pkg::ST_FIN;
        end
      end
      esd_pkg::ST_FIN:   state_next = esd_pkg::ST_DONE;
      esd_pkg::ST_DONE: begin
        if (out_free) begin
          state_next = esd_pkg::ST_IDLE;
        end
      end
      default:           state_next = esd_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    in_ready        = 1'b0;
    case (state)
      esd_pkg::ST_IDLE: begin
        in_ready  = 1'b1;
        cmd.latch = in_valid;
      end
      esd_pkg::ST_REG:   cmd.reg_write   = 1'b1;
      esd_pkg::ST_SCAN:  cmd.scan_issue  = 1'b1;
      esd_pkg::ST_SERVE: cmd.serve_issue = 1'b1;
      esd_pkg::ST_FIN:   cmd.finish      = 1'b1;
      esd_pkg::ST_DONE:  cmd.load_out    = out_free;
      default: begin
      end
    endcase
  end

  // Result register flag: set on load, drop once the sink takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> src/esd_dpath.sv
`default_nettype none

module esd_dpath #(
  parameter int FLOORS = esd_pkg::FLOORS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire esd_pkg::in_t                in_data,
  input  wire esd_pkg::cmd_t               cmd,
  input  wire logic                        cfg_valid,
  input  wire logic [esd_pkg::CFG_IW-1:0]  cfg_index,
  input  wire logic [esd_pkg::CFG_DW-1:0]  cfg_data,
  output esd_pkg::out_t                    out_data,
  output esd_pkg::status_t                 status
);

  localparam int IW     = (FLOORS > 1) ? $clog2(FLOORS) : 1;
  localparam int CW     = (IW > esd_pkg::FLOOR_W) ? IW : esd_pkg::FLOOR_W;
  localparam int DDEPTH = 2 ** CW;
  localparam int K      = esd_pkg::NUM_W + CW + 1;
  localparam int PW     = esd_pkg::NUM_W + K;

  // Reciprocal table: ceil(2^K / (distance + STOP_COST)), exact for every numerator
  logic [K-1:0] recip_tab [DDEPTH];
  for (genvar g = 0; g < DDEPTH; g++) begin : g_recip
    localparam longint unsigned DIV = longint'(g) + longint'(esd_pkg::STOP_COST);
    localparam longint unsigned RV  = ((64'd1 << K) + DIV - 64'd1) / DIV;
    assign recip_tab[g] = RV[K-1:0];
  end

  // Configuration
  logic [esd_pkg::THR_W-1:0]  stop_threshold;
  logic [esd_pkg::LOAD_W-1:0] car_capacity;

  always_ff @(posedge clk) begin
    if (rst) begin
      stop_threshold <= esd_pkg::THRESHOLD_RESET;
      car_capacity   <= esd_pkg::CAPACITY_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        esd_pkg::CFG_STOP_THRESHOLD: stop_threshold <= cfg_data;
        esd_pkg::CFG_CAR_CAPACITY:   car_capacity   <= cfg_data[esd_pkg::LOAD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Item under work
  esd_pkg::in_t item;
  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item <= in_data;
    end
  end

  logic          is_age;
  logic          is_decide;
  logic          is_serve;
  logic          flr_ok;
  logic [IW-1:0] flr_idx;
  logic [CW-1:0] car_x;

  assign is_age    = item.mode == esd_pkg::MODE_AGE;
  assign is_decide = item.mode == esd_pkg::MODE_DECIDE;
  assign is_serve  = item.mode == esd_pkg::MODE_SERVE;
  assign flr_ok    = int'(item.floor) < FLOORS;
  assign flr_idx   = flr_ok ? IW'(item.floor) : '0;
  assign car_x     = CW'(item.car_floor);

  // Call table: active flags in flops, passengers and wait age in memory
  logic [FLOORS-1:0]           active;
  logic [esd_pkg::ENTRY_W-1:0] mem [FLOORS];
  logic [esd_pkg::ENTRY_W-1:0] rd_data;
  logic                        rd_v;
  logic [IW-1:0]               rd_idx;
  logic [IW-1:0]               scan_idx;
  logic                        rd_en;
  logic [IW-1:0]               rd_addr;
  logic                        wr_en;
  logic [IW-1:0]               wr_addr;
  logic [esd_pkg::ENTRY_W-1:0] wr_data;

  logic [esd_pkg::PASS_W-1:0]  rd_pass;
  logic [esd_pkg::WAIT_W-1:0]  rd_wait;
  logic [CW-1:0]               rd_idx_x;
  logic                        reg_ok;
  logic                        age_ok;
  logic                        serve_ok;

  assign rd_pass  = rd_data[esd_pkg::ENTRY_W-1:esd_pkg::WAIT_W];
  assign rd_wait  = rd_data[esd_pkg::WAIT_W-1:0];
  assign rd_idx_x = CW'(rd_idx);

  assign reg_ok   = flr_ok && !active[flr_idx] && (item.floor != item.car_floor);
  assign age_ok   = active[rd_idx] && (rd_idx_x != car_x) && (rd_wait != '1);
  assign serve_ok = flr_ok && active[flr_idx];

  assign rd_en   = cmd.scan_issue || cmd.serve_issue;
  assign rd_addr = cmd.scan_issue ? scan_idx : flr_idx;

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = flr_idx;
    wr_data = {item.passengers, esd_pkg::WAIT_W'(0)};
    if (cmd.reg_write && reg_ok) begin
      wr_en = 1'b1;
    end else if (rd_v && is_age && age_ok) begin
      wr_en   = 1'b1;
      wr_addr = rd_idx;
      wr_data = {rd_pass, rd_wait + 1'b1};
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_v     <= 1'b0;
      scan_idx <= '0;
    end else begin
      rd_v <= rd_en;
      if (cmd.latch) begin
        scan_idx <= '0;
      end else if (cmd.scan_issue) begin
        scan_idx <= scan_idx + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_idx <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= '0;
    end else if (cmd.reg_write && reg_ok) begin
      active[flr_idx] <= 1'b1;
    end else if (rd_v && is_serve && serve_ok) begin
      active[flr_idx] <= 1'b0;
    end
  end

  // Decide pipeline: score operands, quotient, best tracking
  logic                       ahead;
  logic [CW-1:0]              span;
  logic [esd_pkg::NUM_W-1:0]  num;
  logic                       s1_v;
  logic                       s1_elig;
  logic [esd_pkg::NUM_W-1:0]  s1_num;
  logic [K-1:0]               s1_recip;
  logic [IW-1:0]              s1_idx;
  logic [PW-1:0]              prod;
  logic                       s2_v;
  logic                       s2_elig;
  logic [esd_pkg::SCORE_W-1:0] s2_q;
  logic [IW-1:0]              s2_idx;
  logic                       found;
  logic [esd_pkg::SCORE_W-1:0] best;
  logic [IW-1:0]              best_idx;

  assign ahead = item.going_up ? (rd_idx_x > car_x) : (rd_idx_x < car_x);
  assign span  = item.going_up ? (rd_idx_x - car_x) : (car_x - rd_idx_x);
  assign num   = (rd_wait > esd_pkg::BONUS_WAIT)
               ? esd_pkg::NUM_W'(rd_pass) * esd_pkg::SCALE_BONUS
               : esd_pkg::NUM_W'(rd_pass) * esd_pkg::SCALE_PLAIN;
  assign prod  = PW'(s1_num) * PW'(s1_recip);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
      s2_v <= 1'b0;
    end else begin
      s1_v <= rd_v && is_decide;
      s2_v <= s1_v;
    end
  end

  always_ff @(posedge clk) begin
    s1_elig  <= active[rd_idx] && (rd_pass != '0) && ahead;
    s1_num   <= num;
    s1_recip <= recip_tab[span];
    s1_idx   <= rd_idx;
    s2_elig  <= s1_elig;
    s2_q     <= prod[K +: esd_pkg::SCORE_W];
    s2_idx   <= s1_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
    end else if (cmd.latch) begin
      found <= 1'b0;
    end else if (s2_v && s2_elig && (!found || (s2_q > best))) begin
      found <= 1'b1;
    end
  end

  // Strictly greater keeps ties on the lowest floor
  always_ff @(posedge clk) begin
    if (s2_v && s2_elig && (!found || (s2_q > best))) begin
      best     <= s2_q;
      best_idx <= s2_idx;
    end
  end

  // Occupancy, counters, per-item results
  logic [esd_pkg::LOAD_W-1:0]  occupancy;
  logic [esd_pkg::CNT_W-1:0]   cycles_total;
  logic [esd_pkg::CNT_W-1:0]   stops_total;
  logic [esd_pkg::CNT_W-1:0]   skips_total;
  logic [esd_pkg::CNT_W-1:0]   riders_total;
  logic                        res_valid;
  logic [esd_pkg::FLOOR_W-1:0] res_target;
  logic [esd_pkg::SCORE_W-1:0] res_score;
  logic [esd_pkg::LOAD_W-1:0]  res_boarded;
  logic [esd_pkg::LOAD_W-1:0]  room;
  logic [esd_pkg::LOAD_W-1:0]  brd;

  assign room = (car_capacity > occupancy) ? (car_capacity - occupancy) : '0;
  assign brd  = (esd_pkg::LOAD_W'(rd_pass) > room) ? room : esd_pkg::LOAD_W'(rd_pass);

  always_ff @(posedge clk) begin
    if (rst) begin
      occupancy    <= '0;
      cycles_total <= '0;
      stops_total  <= '0;
      skips_total  <= '0;
      riders_total <= '0;
      res_valid    <= 1'b0;
      res_target   <= '0;
      res_score    <= '0;
      res_boarded  <= '0;
    end else if (cmd.latch) begin
      res_valid   <= 1'b0;
      res_target  <= '0;
      res_score   <= '0;
      res_boarded <= '0;
    end else if (rd_v && is_serve && serve_ok) begin
      occupancy    <= (occupancy > car_capacity) ? car_capacity : occupancy + brd;
      riders_total <= riders_total + esd_pkg::CNT_W'(brd);
      stops_total  <= stops_total + 1'b1;
      res_boarded  <= brd;
    end else if (cmd.finish && is_decide) begin
      cycles_total <= cycles_total + 1'b1;
      if (found) begin
        res_score <= best;
        if ({1'b0, best} < stop_threshold) begin
          skips_total <= skips_total + 1'b1;
        end else begin
          res_valid  <= 1'b1;
          res_target <= esd_pkg::FLOOR_W'(best_idx);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.target_valid  <= res_valid;
      out_data.target_floor  <= res_target;
      out_data.best_score    <= res_score;
      out_data.boarded       <= res_boarded;
      out_data.load          <= occupancy;
      out_data.decide_count  <= cycles_total;
      out_data.stop_count    <= stops_total;
      out_data.skip_count    <= skips_total;
      out_data.boarded_total <= riders_total;
    end
  end

  assign status.scan_last  = scan_idx == IW'(FLOORS - 1);
  assign status.pipe_empty = !(rd_v || s1_v || s2_v);

endmodule

`default_nettype wire

>>> src/elevator_stop_dispatcher_unit.sv
`default_nettype none

// Channel   Direction  Handshake               Payload
// in        sink       in_valid / in_ready     in_data   (esd_pkg::in_t)
// out       source     out_valid / out_ready   out_data  (esd_pkg::out_t)
// cfg       sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// Age and decide walk the call table one floor per cycle; decide adds operand, multiply
// and compare stages. Reset (rst, synchronous) clears the call flags, occupancy and
// counters and loads the register defaults. A stalled result holds in the output
// register while the next item is taken in and worked; that item then waits until
// the register frees.

module elevator_stop_dispatcher_unit #(
  parameter int FLOORS = esd_pkg::FLOORS_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire esd_pkg::in_t               in_data,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output esd_pkg::out_t                   out_data,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [esd_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [esd_pkg::CFG_DW-1:0] cfg_data
);

  esd_pkg::cmd_t    cmd;
  esd_pkg::status_t status;

  // Register writes are always accepted
  assign cfg_ready = 1'b1;

  // Sequencer: takes one transfer, walks the table for age and decide, loads the result register
  esd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_mode   (in_data.mode),
    .out_ready (out_ready),
    .status    (status),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .cmd       (cmd)
  );

  // Call table, scoring pipeline, occupancy, counters and result register
  esd_dpath #(
    .FLOORS (FLOORS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_data  (out_data),
    .status    (status)
  );

endmodule

`default_nettype wire

>>> src/esd_chk.sv
`default_nettype none

module esd_chk (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire esd_pkg::out_t out_data
);

  // A pending result holds until transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result dropped or changed while stalled");

  // No target floor without a target
  a_no_floor: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.target_valid |-> out_data.target_floor == '0)
    else $error("target floor set without target");

  // A chosen stop always carries a nonzero score and no boarding
  a_score: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.target_valid |-> out_data.best_score != '0
      && out_data.boarded == '0)
    else $error("target without score or with boarding");

  // Boarding only comes from a serve, which reports no decision
  a_board: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.boarded != '0 |-> out_data.best_score == '0
      && !out_data.target_valid)
    else $error("boarding mixed with decision result");

endmodule

bind elevator_stop_dispatcher_unit esd_chk u_esd_chk (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

>>> test/esd_dispatch_checker.sv
`default_nettype none

module esd_dispatch_checker (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  input  wire logic                       in_ready,
  input  wire esd_pkg::in_t               in_data,
  input  wire logic                       out_valid,
  input  wire logic                       out_ready,
  input  wire esd_pkg::out_t              out_data,
  input  wire logic                       cfg_valid,
  input  wire logic                       cfg_ready,
  input  wire logic [esd_pkg::CFG_IW-1:0] cfg_index,
  input  wire logic [esd_pkg::CFG_DW-1:0] cfg_data,
  output int                              reports_waiting,
  output int                              mismatches
);
  import esd_pkg::*;

  localparam int FLOOR_COUNT = 16;

  // Shadow of the hall-call table and car state
  logic             call_on  [FLOOR_COUNT];
  logic [PASS_W-1:0] call_est [FLOOR_COUNT];
  logic [WAIT_W-1:0] call_age [FLOOR_COUNT];
  int unsigned      car_load;
  logic [CNT_W-1:0] decide_total;
  logic [CNT_W-1:0] stop_total;
  logic [CNT_W-1:0] skip_total;
  logic [CNT_W-1:0] rider_total;
  int unsigned      stop_thr;
  int unsigned      car_cap;

  out_t reports_due[$];
  out_t want;

  initial begin
    reports_waiting = 0;
    mismatches = 0;
  end

  // Apply one command to the shadow table and return the dispatch report.
  function automatic out_t dispatch_step(input in_t req);
    out_t        res;
    int unsigned span;
    int unsigned gain;
    int unsigned score;
    int unsigned best;
    int unsigned room;
    int unsigned brd;
    logic        found;
    logic [FLOOR_W-1:0] pick;
    res = '0;
    found = 1'b0;
    best = 0;
    pick = '0;
    case (req.mode)
      MODE_REG: begin
        if (!call_on[req.floor] && req.floor != req.car_floor) begin
          call_on[req.floor]  = 1'b1;
          call_est[req.floor] = req.passengers;
          call_age[req.floor] = '0;
        end
      end
      MODE_AGE: begin
        for (int f = 0; f < FLOOR_COUNT; f++) begin
          if (call_on[f] && f != int'(req.car_floor) && call_age[f] != 8'hFF)
            call_age[f] = call_age[f] + 8'd1;
        end
      end
      MODE_DECIDE: begin
        decide_total = decide_total + 1;
        for (int f = 0; f < FLOOR_COUNT; f++) begin
          if (call_on[f] && call_est[f] != 0 &&
              (req.going_up ? (f > int'(req.car_floor)) : (f < int'(req.car_floor)))) begin
            span = req.going_up ? (f - int'(req.car_floor)) : (int'(req.car_floor) - f);
            gain = (call_age[f] > BONUS_WAIT) ? SCALE_BONUS : SCALE_PLAIN;
            score = (int'(call_est[f]) * gain) / (span + STOP_COST);
            // strict compare keeps the lowest floor on a tie
            if (!found || score > best) begin
              found = 1'b1;
              best  = score;
              pick  = FLOOR_W'(f);
            end
          end
        end
        if (found) begin
          res.best_score = SCORE_W'(best);
          if (best < stop_thr) begin
            skip_total = skip_total + 1;
          end else begin
            res.target_valid = 1'b1;
            res.target_floor = pick;
          end
        end
      end
      default: begin
        if (call_on[req.floor]) begin
          room = (car_cap > car_load) ? car_cap - car_load : 0;
          brd = (int'(call_est[req.floor]) < room) ? int'(call_est[req.floor]) : room;
          car_load = car_load + brd;
          if (car_load > car_cap) car_load = car_cap;
          rider_total = rider_total + brd;
          stop_total = stop_total + 1;
          call_on[req.floor]  = 1'b0;
          call_est[req.floor] = '0;
          call_age[req.floor] = '0;
          res.boarded = LOAD_W'(brd);
        end
      end
    endcase
    res.load          = LOAD_W'(car_load);
    res.decide_count  = decide_total;
    res.stop_count    = stop_total;
    res.skip_count    = skip_total;
    res.boarded_total = rider_total;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int f = 0; f < FLOOR_COUNT; f++) begin
        call_on[f]  = 1'b0;
        call_est[f] = '0;
        call_age[f] = '0;
      end
      car_load     = 0;
      decide_total = '0;
      stop_total   = '0;
      skip_total   = '0;
      rider_total  = '0;
      stop_thr     = THRESHOLD_RESET;
      car_cap      = CAPACITY_RESET;
      reports_due.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == CFG_STOP_THRESHOLD) stop_thr = cfg_data[THR_W-1:0];
        else if (cfg_index == CFG_CAR_CAPACITY) car_cap = cfg_data[LOAD_W-1:0];
      end
      if (out_valid === 1'b1 && out_ready) begin
        if (reports_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, out_data);
          mismatches++;
        end else begin
          want = reports_due.pop_front();
          check_field("target_valid", want.target_valid, out_data.target_valid);
          check_field("target_floor", want.target_floor, out_data.target_floor);
          check_field("best_score", want.best_score, out_data.best_score);
          check_field("boarded", want.boarded, out_data.boarded);
          check_field("load", want.load, out_data.load);
          check_field("decide_count", want.decide_count, out_data.decide_count);
          check_field("stop_count", want.stop_count, out_data.stop_count);
          check_field("skip_count", want.skip_count, out_data.skip_count);
          check_field("boarded_total", want.boarded_total, out_data.boarded_total);
        end
      end
      if (in_valid && in_ready) reports_due.push_back(dispatch_step(in_data));
    end
    reports_waiting = reports_due.size();
  end

endmodule

`default_nettype wire

>>> test/elevator_stop_dispatcher_unit_tb.sv
`default_nettype none

module elevator_stop_dispatcher_unit_tb;
  import esd_pkg::*;

  // Longest stretch without any transfer before the run is called hung.
  localparam int STALL_LIMIT  = 4000;
  localparam int HOLD_CYCLES  = 300;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_ready;
  in_t                 in_data;
  logic                out_valid;
  logic                out_ready;
  out_t                out_data;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [CFG_IW-1:0]   cfg_index;
  logic [CFG_DW-1:0]   cfg_data;

  int reports_waiting;
  int mismatches;
  int idle_cycles;

  // Handshake between the sender and the receiver process for the long hold-off
  int   hold_order;
  int   hold_done;
  // No idling on either side while set
  logic steady;

  // Stimulus-side bookkeeping: where the car is and which floors were called
  logic [FLOOR_W-1:0] car_pos;
  logic [15:0]        called;

  elevator_stop_dispatcher_unit uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  esd_dispatch_checker checker_i (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_data        (out_data),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .reports_waiting (reports_waiting),
    .mismatches      (mismatches)
  );

  initial clk = 1'b0;
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: count cycles with no transfer on any channel.
  initial idle_cycles = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid === 1'b1 && out_ready) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Receiver: mostly ready, short stalls, a few long ones, and the
  // long hold-off whenever the sender asks for it.
  initial begin
    out_ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (hold_order != hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(negedge clk);
        hold_done++;
      end else if (steady) begin
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(10, 50)) @(negedge clk);
        else repeat ($urandom_range(0, 2)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(0, 15)) @(negedge clk);
      end
    end
  end

  function automatic in_t mk(input mode_t m, input int flr, input int pass,
                             input int car, input bit up);
    in_t d;
    d.mode       = m;
    d.floor      = FLOOR_W'(flr);
    d.passengers = PASS_W'(pass);
    d.car_floor  = FLOOR_W'(car);
    d.going_up   = up;
    return d;
  endfunction

  // Offer one item after a random gap and hold it until the transfer.
  // Valid stays high across back-to-back items.
  task automatic offer(input in_t d);
    int gap;
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Drop valid and wait until every expected report has come back.
  task automatic quiesce();
    @(negedge clk);
    in_valid <= 1'b0;
    while (reports_waiting != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input int val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DW'(val);
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Random traffic: calls, ticks, decisions and stops, with serves mostly
  // aimed at floors that were called. Weights are percentages, serve is the rest.
  task automatic run_phase(input int count, input int w_reg, input int w_age,
                           input int w_dec, input int hold_at, input int pause_at);
    in_t d;
    int  r;
    int  start;
    bit  picked;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(0, 9) == 0) car_pos = FLOOR_W'($urandom_range(0, 15));
      d.car_floor  = car_pos;
      d.going_up   = 1'($urandom_range(0, 1));
      d.floor      = FLOOR_W'($urandom_range(0, 15));
      d.passengers = PASS_W'($urandom_range(0, 15));
      r = $urandom_range(0, 99);
      if (r < w_reg) begin
        d.mode = MODE_REG;
        if (d.floor != car_pos) called[d.floor] = 1'b1;
      end else if (r < w_reg + w_age) begin
        d.mode = MODE_AGE;
      end else if (r < w_reg + w_age + w_dec) begin
        d.mode = MODE_DECIDE;
      end else begin
        d.mode = MODE_SERVE;
        if (called != '0 && $urandom_range(0, 4) != 0) begin
          start = $urandom_range(0, 15);
          picked = 1'b0;
          for (int k = 0; k < 16; k++) begin
            if (!picked && called[FLOOR_W'(start + k)]) begin
              d.floor = FLOOR_W'(start + k);
              picked = 1'b1;
            end
          end
        end
        // the car moves to the floor it serves
        called[d.floor] = 1'b0;
        car_pos = d.floor;
      end
      if (n == hold_at) hold_order++;
      if (n == pause_at) quiesce();
      offer(d);
    end
  endtask

  initial begin
    in_t opening[$];
    rst        = 1'b1;
    in_valid   = 1'b0;
    in_data    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    hold_order = 0;
    hold_done  = 0;
    steady     = 1'b0;
    car_pos    = '0;
    called     = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed opening under the reset settings (threshold 128, capacity 8)
    opening.push_back(mk(MODE_DECIDE, 0, 0, 0, 1));   // empty table: no candidate
    opening.push_back(mk(MODE_REG, 0, 9, 0, 1));      // call on the car's floor: dropped
    opening.push_back(mk(MODE_REG, 15, 15, 0, 1));
    opening.push_back(mk(MODE_REG, 15, 3, 0, 0));     // floor already active: dropped
    opening.push_back(mk(MODE_REG, 5, 0, 0, 1));      // zero passengers, never picked
    opening.push_back(mk(MODE_REG, 2, 4, 0, 1));
    opening.push_back(mk(MODE_REG, 6, 8, 0, 1));
    opening.push_back(mk(MODE_DECIDE, 0, 0, 0, 1));   // floors 2 and 6 tie, lower wins
    opening.push_back(mk(MODE_DECIDE, 15, 15, 15, 0)); // heading down from the top
    opening.push_back(mk(MODE_DECIDE, 0, 0, 15, 1));  // nothing above the top floor
    repeat (6) opening.push_back(mk(MODE_AGE, 0, 0, 2, 1)); // floor 2 held back
    opening.push_back(mk(MODE_DECIDE, 0, 0, 0, 1));   // wait bonus lifts floor 6
    opening.push_back(mk(MODE_SERVE, 6, 0, 6, 1));    // fills the car
    opening.push_back(mk(MODE_SERVE, 2, 0, 2, 0));    // no room left
    opening.push_back(mk(MODE_SERVE, 2, 0, 2, 0));    // floor no longer active
    opening.push_back(mk(MODE_SERVE, 15, 15, 15, 1));
    opening.push_back(mk(MODE_SERVE, 5, 0, 5, 0));
    opening.push_back(mk(MODE_REG, 9, 1, 0, 1));
    opening.push_back(mk(MODE_DECIDE, 0, 0, 0, 1));   // score below threshold: skip
    opening.push_back(mk(MODE_SERVE, 9, 0, 9, 0));
    foreach (opening[i]) offer(opening[i]);
    quiesce();

    // Capacity dropped below occupancy, threshold at the bottom
    write_reg(CFG_STOP_THRESHOLD, 0);
    write_reg(CFG_CAR_CAPACITY, 1);
    run_phase(150, 35, 15, 25, -1, -1);
    quiesce();

    // Threshold at the top: every decision with a candidate is skipped
    write_reg(CFG_STOP_THRESHOLD, 4095);
    write_reg(CFG_CAR_CAPACITY, 40);
    run_phase(150, 35, 15, 25, -1, -1);
    quiesce();

    // Receiver holds off while the sender keeps offering; then a full pause
    write_reg(CFG_STOP_THRESHOLD, 128);
    write_reg(CFG_CAR_CAPACITY, 100);
    run_phase(300, 35, 15, 25, 60, 200);
    quiesce();

    // Mostly ticks and no serves, so wait ages run into saturation
    write_reg(CFG_STOP_THRESHOLD, $urandom_range(0, 600));
    write_reg(CFG_CAR_CAPACITY, 180);
    run_phase(350, 15, 80, 5, -1, -1);
    quiesce();

    // Back-to-back traffic with no idling, full capacity
    steady = 1'b1;
    write_reg(CFG_STOP_THRESHOLD, $urandom_range(0, 1600));
    write_reg(CFG_CAR_CAPACITY, 255);
    run_phase(250, 35, 15, 25, -1, -1);
    quiesce();
    steady = 1'b0;

    // Capacity lowered again below the load
    write_reg(CFG_STOP_THRESHOLD, $urandom_range(0, 4095));
    write_reg(CFG_CAR_CAPACITY, 3);
    run_phase(250, 30, 20, 25, -1, -1);
    quiesce();

    // Let any stray result show up before the verdict
    repeat (40) @(negedge clk);
    if (mismatches == 0 && reports_waiting == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

`default_nettype wire

>>> filelist.f
src/esd_pkg.sv
src/esd_ctrl.sv
src/esd_dpath.sv
src/elevator_stop_dispatcher_unit.sv
src/esd_chk.sv
test/esd_dispatch_checker.sv
test/elevator_stop_dispatcher_unit_tb.sv
